// ===== rtl/core/esn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package esn_pkg;

  localparam int Res = 32;
  localparam int Inp = 4;
  localparam int Outs = 4;

  localparam int SW = (Res > 1) ? $clog2(Res) : 1;
  localparam int KW = (Inp > 1) ? $clog2(Inp) : 1;
  localparam int JW = $clog2(Res + Inp + 1);
  localparam int MaxRow = (Res > Outs) ? Res : Outs;
  localparam int IW = (MaxRow > 1) ? $clog2(MaxRow) : 1;
  localparam int RecAW = (Res * Res > 1) ? $clog2(Res * Res) : 1;
  localparam int InAW = (Res * Inp > 1) ? $clog2(Res * Inp) : 1;
  localparam int OutAW = (Outs * Res > 1) ? $clog2(Outs * Res) : 1;
  localparam int AccW = 33 + $clog2(Res + Inp + 1);

  localparam logic [12:0] QOne = 13'd4096;
  localparam logic [11:0] TanhTop = 12'd4093;

  localparam logic [2:0] CmdRecW = 3'd0;
  localparam logic [2:0] CmdInW = 3'd1;
  localparam logic [2:0] CmdOutW = 3'd2;
  localparam logic [2:0] CmdSample = 3'd3;
  localparam logic [2:0] CmdClear = 3'd4;

  localparam logic [1:0] SrcRec = 2'd0;
  localparam logic [1:0] SrcIn = 2'd1;
  localparam logic [1:0] SrcOut = 2'd2;

  localparam logic KindState = 1'b0;
  localparam logic KindReadout = 1'b1;

  typedef struct packed {
    logic          load;
    logic          issue;
    logic [1:0]    src;
    logic [IW-1:0] row;
    logic [JW-1:0] col;
    logic          acc_clr;
    logic          st_rd;
    logic          wr_next;
    logic          flip;
    logic          out_ld;
    logic          out_kind;
    logic          final_res;
  } esn_cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic out_free;
  } esn_stat_t;

  function automatic logic [11:0] tanh_tab(input logic [4:0] idx);
    logic [11:0] y;
    unique case (idx)
      5'd0:  y = 12'd0;
      5'd1:  y = 12'd1003;
      5'd2:  y = 12'd1893;
      5'd3:  y = 12'd2602;
      5'd4:  y = 12'd3119;
      5'd5:  y = 12'd3475;
      5'd6:  y = 12'd3707;
      5'd7:  y = 12'd3856;
      5'd8:  y = 12'd3949;
      5'd9:  y = 12'd4006;
      5'd10: y = 12'd4041;
      5'd11: y = 12'd4062;
      5'd12: y = 12'd4076;
      5'd13: y = 12'd4084;
      5'd14: y = 12'd4089;
      5'd15: y = 12'd4091;
      default: y = TanhTop;
    endcase
    return y;
  endfunction

  // Round half up from Q.24 to Q.12, then saturate to 16 bits.
  function automatic logic signed [15:0] round_sat(input logic signed [47:0] v);
    logic signed [47:0] r;
    logic signed [15:0] y;
    r = (v + 48'sd2048) >>> 12;
    if (r > 48'sd32767) y = 16'sh7fff;
    else if (r < -48'sd32768) y = 16'sh8000;
    else y = r[15:0];
    return y;
  endfunction

  function automatic logic signed [15:0] tanh_q12(input logic signed [15:0] s);
    logic [15:0] a;
    logic [4:0]  idx;
    logic [11:0] lo;
    logic [11:0] d;
    logic [21:0] p;
    logic [11:0] y;
    a = s[15] ? 16'(-s) : 16'(s);
    idx = {1'b0, a[13:10]};
    lo = tanh_tab(idx);
    d = tanh_tab(idx + 5'd1) - lo;
    p = 22'(d) * 22'(a[9:0]) + 22'd512;
    if (a >= 16'd16384) y = TanhTop;
    else y = lo + 12'(p >> 10);
    return s[15] ? -$signed({4'b0, y}) : $signed({4'b0, y});
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/esn_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module esn_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire esn_pkg::esn_cmd_t   cmd_i,
  output      esn_pkg::esn_stat_t  stat_o,
  input  wire logic [2:0]          command_i,
  input  wire logic [5:0]          row_i,
  input  wire logic [5:0]          column_i,
  input  wire logic signed [15:0]  value_i,
  input  wire logic                cfg_we_i,
  input  wire logic [12:0]         cfg_wdata_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic                kind_o,
  output      logic [5:0]          index_o,
  output      logic signed [15:0]  result_value_o,
  output      logic                final_res_o
);

  localparam int SW = esn_pkg::SW;
  localparam int KW = esn_pkg::KW;

  logic signed [15:0] rec_mem [esn_pkg::Res * esn_pkg::Res];
  logic signed [15:0] in_mem [esn_pkg::Res * esn_pkg::Inp];
  logic signed [15:0] out_mem [esn_pkg::Outs * esn_pkg::Res];
  logic signed [15:0] st_mem [2 ** (SW + 1)];
  logic signed [15:0] inbuf_q [esn_pkg::Inp];

  logic [12:0] leak_q;
  logic        cur_q, zero_q;
  logic        v1_q, v2_q;
  logic [1:0]  src_q;
  logic [KW-1:0] k_q;
  logic signed [15:0] rw_q, iw_q, ow_q, st_q;
  logic signed [31:0] prod_q;
  logic signed [esn_pkg::AccW-1:0] acc_q;
  logic signed [15:0] s_q, t_q;
  logic signed [29:0] p1_q, p2_q;
  logic        out_valid_q, kind_q, final_q;
  logic [5:0]  index_q;
  logic signed [15:0] value_q;

  logic [SW-1:0] i_sw, j_sw;
  logic [KW-1:0] k_d;
  logic [esn_pkg::RecAW-1:0] rec_waddr, rec_raddr;
  logic [esn_pkg::InAW-1:0]  in_waddr, in_raddr;
  logic [esn_pkg::OutAW-1:0] out_waddr, out_raddr;
  logic [SW:0] st_raddr, st_waddr;
  logic rec_ok, in_ok, out_ok, smp_ok;
  logic signed [15:0] w_sel, op_sel, x_old;
  logic [12:0] a_eff;
  logic out_free;

  assign i_sw = SW'(cmd_i.row);
  assign j_sw = SW'(cmd_i.col);
  assign k_d = KW'(cmd_i.col - esn_pkg::JW'(esn_pkg::Res));

  assign rec_ok = (int'(row_i) < esn_pkg::Res) && (int'(column_i) < esn_pkg::Res);
  assign in_ok = (int'(row_i) < esn_pkg::Res) && (int'(column_i) < esn_pkg::Inp);
  assign out_ok = (int'(row_i) < esn_pkg::Outs) && (int'(column_i) < esn_pkg::Res);
  assign smp_ok = int'(column_i) < esn_pkg::Inp;

  assign rec_waddr = esn_pkg::RecAW'(row_i) * esn_pkg::RecAW'(esn_pkg::Res)
                   + esn_pkg::RecAW'(column_i);
  assign in_waddr = esn_pkg::InAW'(row_i) * esn_pkg::InAW'(esn_pkg::Inp)
                  + esn_pkg::InAW'(column_i);
  assign out_waddr = esn_pkg::OutAW'(row_i) * esn_pkg::OutAW'(esn_pkg::Res)
                   + esn_pkg::OutAW'(column_i);
  assign rec_raddr = esn_pkg::RecAW'(i_sw) * esn_pkg::RecAW'(esn_pkg::Res)
                   + esn_pkg::RecAW'(j_sw);
  assign in_raddr = esn_pkg::InAW'(i_sw) * esn_pkg::InAW'(esn_pkg::Inp)
                  + esn_pkg::InAW'(k_d);
  assign out_raddr = esn_pkg::OutAW'(i_sw) * esn_pkg::OutAW'(esn_pkg::Res)
                   + esn_pkg::OutAW'(j_sw);
  assign st_raddr = {cur_q, cmd_i.st_rd ? i_sw : j_sw};
  assign st_waddr = {~cur_q, i_sw};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && command_i == esn_pkg::CmdRecW && rec_ok) rec_mem[rec_waddr] <= value_i;
    if (cmd_i.load && command_i == esn_pkg::CmdInW && in_ok) in_mem[in_waddr] <= value_i;
    if (cmd_i.load && command_i == esn_pkg::CmdOutW && out_ok) out_mem[out_waddr] <= value_i;
    if (cmd_i.issue && cmd_i.src == esn_pkg::SrcRec) rw_q <= rec_mem[rec_raddr];
    if (cmd_i.issue && cmd_i.src == esn_pkg::SrcIn) iw_q <= in_mem[in_raddr];
    if (cmd_i.issue && cmd_i.src == esn_pkg::SrcOut) ow_q <= out_mem[out_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_next) st_mem[st_waddr] <= esn_pkg::round_sat(48'(p1_q) + 48'(p2_q));
    if ((cmd_i.issue && cmd_i.src != esn_pkg::SrcIn) || cmd_i.st_rd) st_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_q <= esn_pkg::QOne;
      cur_q <= 1'b0;
      zero_q <= 1'b1;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int n = 0; n < esn_pkg::Inp; n++) inbuf_q[n] <= '0;
    end else begin
      if (cfg_we_i) leak_q <= cfg_wdata_i;
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.load && command_i == esn_pkg::CmdSample && smp_ok) begin
        inbuf_q[KW'(column_i)] <= value_i;
      end
      if (cmd_i.load && command_i == esn_pkg::CmdClear) zero_q <= 1'b1;
      if (cmd_i.flip) begin
        cur_q <= ~cur_q;
        zero_q <= 1'b0;
        for (int n = 0; n < esn_pkg::Inp; n++) inbuf_q[n] <= '0;
      end
    end
  end

  always_comb begin
    case (src_q)
      esn_pkg::SrcIn:  w_sel = iw_q;
      esn_pkg::SrcOut: w_sel = ow_q;
      default:         w_sel = rw_q;
    endcase
  end

  assign x_old = zero_q ? 16'sd0 : st_q;
  assign op_sel = (src_q == esn_pkg::SrcIn) ? inbuf_q[k_q] : x_old;
  assign a_eff = (leak_q > esn_pkg::QOne) ? esn_pkg::QOne : leak_q;

  // MAC pipeline: read, multiply, accumulate; finish stages run every cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      src_q <= cmd_i.src;
      k_q <= k_d;
    end
    prod_q <= w_sel * op_sel;
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (v2_q) acc_q <= acc_q + esn_pkg::AccW'(prod_q);
    s_q <= esn_pkg::round_sat(48'(acc_q));
    t_q <= esn_pkg::tanh_q12(s_q);
    p1_q <= $signed({1'b0, esn_pkg::QOne - a_eff}) * x_old;
    p2_q <= $signed({1'b0, a_eff}) * t_q;
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      kind_q <= cmd_i.out_kind;
      index_q <= 6'(cmd_i.row);
      final_q <= cmd_i.final_res;
      value_q <= (cmd_i.out_kind == esn_pkg::KindReadout) ?
                 esn_pkg::round_sat(48'(acc_q)) : st_q;
    end
  end

  assign stat_o.mac_busy = v1_q || v2_q;
  assign stat_o.out_free = out_free;
  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign index_o = index_q;
  assign result_value_o = value_q;
  assign final_res_o = final_q;

endmodule
`default_nettype wire

// ===== rtl/core/esn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module esn_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [2:0]         command_i,
  input  wire logic               last_i,
  input  wire esn_pkg::esn_stat_t stat_i,
  output      esn_pkg::esn_cmd_t  cmd_o
);

  localparam int IW = esn_pkg::IW;
  localparam int JW = esn_pkg::JW;

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SMac     = 4'd1;
  localparam logic [3:0] SDrain   = 4'd2;
  localparam logic [3:0] SFin1    = 4'd3;
  localparam logic [3:0] SFin2    = 4'd4;
  localparam logic [3:0] SFin3    = 4'd5;
  localparam logic [3:0] SFin4    = 4'd6;
  localparam logic [3:0] SEmitRd  = 4'd7;
  localparam logic [3:0] SEmitLd  = 4'd8;
  localparam logic [3:0] SRoMac   = 4'd9;
  localparam logic [3:0] SRoDrain = 4'd10;
  localparam logic [3:0] SRoOut   = 4'd11;

  localparam logic [IW-1:0] LastNeuron = IW'(esn_pkg::Res - 1);
  localparam logic [IW-1:0] LastOut = IW'(esn_pkg::Outs - 1);
  localparam logic [JW-1:0] LastStepTerm = JW'(esn_pkg::Res + esn_pkg::Inp - 1);
  localparam logic [JW-1:0] LastRoTerm = JW'(esn_pkg::Res - 1);
  localparam logic [JW-1:0] ResCount = JW'(esn_pkg::Res);

  logic [3:0] state_q, state_d;
  logic [IW-1:0] i_q, i_d;
  logic [JW-1:0] j_q, j_d;

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    cmd_o = '0;
    cmd_o.row = i_q;
    cmd_o.col = j_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (command_i == esn_pkg::CmdSample && last_i) begin
            cmd_o.acc_clr = 1'b1;
            i_d = '0;
            j_d = '0;
            state_d = SMac;
          end
        end
      end
      SMac: begin
        cmd_o.issue = 1'b1;
        cmd_o.src = (j_q < ResCount) ? esn_pkg::SrcRec : esn_pkg::SrcIn;
        if (j_q == LastStepTerm) begin
          j_d = '0;
          state_d = SDrain;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      SDrain: if (!stat_i.mac_busy) state_d = SFin1;
      SFin1: begin
        // fetch the old state element for the blend
        cmd_o.st_rd = 1'b1;
        state_d = SFin2;
      end
      SFin2: state_d = SFin3;
      SFin3: state_d = SFin4;
      SFin4: begin
        cmd_o.wr_next = 1'b1;
        cmd_o.acc_clr = 1'b1;
        if (i_q == LastNeuron) begin
          cmd_o.flip = 1'b1;
          i_d = '0;
          state_d = SEmitRd;
        end else begin
          i_d = i_q + 1'b1;
          state_d = SMac;
        end
      end
      SEmitRd: begin
        cmd_o.st_rd = 1'b1;
        state_d = SEmitLd;
      end
      SEmitLd: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.out_kind = esn_pkg::KindState;
          if (i_q == LastNeuron) begin
            cmd_o.acc_clr = 1'b1;
            i_d = '0;
            state_d = SRoMac;
          end else begin
            i_d = i_q + 1'b1;
            state_d = SEmitRd;
          end
        end
      end
      SRoMac: begin
        cmd_o.issue = 1'b1;
        cmd_o.src = esn_pkg::SrcOut;
        if (j_q == LastRoTerm) begin
          j_d = '0;
          state_d = SRoDrain;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      SRoDrain: if (!stat_i.mac_busy) state_d = SRoOut;
      SRoOut: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.out_kind = esn_pkg::KindReadout;
          cmd_o.final_res = (i_q == LastOut);
          if (i_q == LastOut) begin
            i_d = '0;
            state_d = SIdle;
          end else begin
            cmd_o.acc_clr = 1'b1;
            i_d = i_q + 1'b1;
            state_d = SRoMac;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      i_q <= '0;
      j_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  a_out_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> stat_i.out_free) else $error("output word loaded while occupied");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat_i.mac_busy) else $error("input taken with MAC pipeline busy");

  a_flip_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flip |-> (i_q == LastNeuron)) else $error("state bank flipped early");

  a_issue_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> !in_ready_o) else $error("MAC issue while accepting input");

endmodule
`default_nettype wire

// ===== rtl/core/echo_state_network_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Leaky echo state network step, Q4.12. Load words (weights, samples, clear)
// are accepted whenever the unit is idle. A sample word marked last starts a
// step that holds in_ready_o low until the last result word is loaded for
// output: per neuron, 36 products pass one shared multiply-accumulate
// pipeline, then drain, tanh and leak blend follow; then 32 state words and
// 4 readout words follow. Output back-pressure stalls the emission of these
// words. Neuron state lives in a two-bank memory that swaps once every
// neuron of the step is updated.
module echo_state_network_step_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [2:0]         command_i,
  input  wire logic [5:0]         row_i,
  input  wire logic [5:0]         column_i,
  input  wire logic signed [15:0] value_i,
  input  wire logic               last_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               kind_o,
  output      logic [5:0]         index_o,
  output      logic signed [15:0] result_value_o,
  output      logic               final_res_o,
  input  wire logic               cfg_we_i,
  input  wire logic [12:0]        cfg_wdata_i
);

  esn_pkg::esn_cmd_t  cmd;
  esn_pkg::esn_stat_t stat;

  esn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .last_i     (last_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  esn_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .command_i      (command_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .index_o        (index_o),
    .result_value_o (result_value_o),
    .final_res_o    (final_res_o)
  );

endmodule
`default_nettype wire

// ===== verif/echo_state_network_step_unit_test.sv =====
`timescale 1ns / 1ps
module echo_state_network_step_unit_test;

  localparam logic [2:0] CmdTop = 3'd7;
  localparam logic [2:0] CmdSpareLo = 3'd5;
  localparam logic [2:0] CmdSpareMid = 3'd6;
  localparam int QUnit = 4096;

  typedef struct packed {
    logic               kind;
    logic [5:0]         index;
    logic signed [15:0] value;
    logic               fin;
  } esn_word_t;

  // Tracks the network state and holds the words a step should emit.
  class esn_scoreboard;
    shortint   rec_w[esn_pkg::Res*esn_pkg::Res];
    shortint   in_w[esn_pkg::Res*esn_pkg::Inp];
    shortint   out_w[esn_pkg::Outs*esn_pkg::Res];
    shortint   state[esn_pkg::Res];
    shortint   samples[esn_pkg::Inp];
    int        leak;
    int        errors;
    esn_word_t pending_words[$];

    function new();
      foreach (rec_w[i]) rec_w[i] = 0;
      foreach (in_w[i]) in_w[i] = 0;
      foreach (out_w[i]) out_w[i] = 0;
      foreach (state[i]) state[i] = 0;
      foreach (samples[i]) samples[i] = 0;
      leak = QUnit;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return pending_words.size();
    endfunction

    function shortint sat_q12(input longint v);
      longint r;
      r = (v + 2048) >>> 12;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return shortint'(r);
    endfunction

    function int tanh_q12(input int s);
      int pts[17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
                      4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};
      int a;
      int y;
      a = (s < 0) ? -s : s;
      if (a >= 16384) y = 4093;
      else y = pts[a >> 10] + (((pts[(a >> 10) + 1] - pts[a >> 10]) * (a & 1023) + 512) >> 10);
      return (s < 0) ? -y : y;
    endfunction

    function void note_input(input logic [2:0] cmd, input logic [5:0] row,
                             input logic [5:0] col, input logic signed [15:0] val,
                             input logic last);
      shortint   nxt[esn_pkg::Res];
      longint    acc;
      int        a;
      esn_word_t w;
      case (cmd)
        esn_pkg::CmdRecW:
          if (row < esn_pkg::Res && col < esn_pkg::Res) rec_w[row*esn_pkg::Res + col] = val;
        esn_pkg::CmdInW:
          if (row < esn_pkg::Res && col < esn_pkg::Inp) in_w[row*esn_pkg::Inp + col] = val;
        esn_pkg::CmdOutW:
          if (row < esn_pkg::Outs && col < esn_pkg::Res) out_w[row*esn_pkg::Res + col] = val;
        esn_pkg::CmdClear: foreach (state[i]) state[i] = 0;
        esn_pkg::CmdSample: begin
          if (col < esn_pkg::Inp) samples[col] = val;
          if (last) begin
            a = (leak > QUnit) ? QUnit : leak;
            for (int i = 0; i < esn_pkg::Res; i++) begin
              acc = 0;
              for (int j = 0; j < esn_pkg::Res; j++)
                acc += longint'(rec_w[i*esn_pkg::Res + j]) * state[j];
              for (int j = 0; j < esn_pkg::Inp; j++)
                acc += longint'(in_w[i*esn_pkg::Inp + j]) * samples[j];
              nxt[i] = sat_q12(longint'(QUnit - a) * state[i] +
                               longint'(a) * tanh_q12(sat_q12(acc)));
            end
            state = nxt;
            foreach (samples[i]) samples[i] = 0;
            for (int i = 0; i < esn_pkg::Res; i++) begin
              w = '{esn_pkg::KindState, 6'(i), state[i], 1'b0};
              pending_words = {pending_words, w};
            end
            for (int o = 0; o < esn_pkg::Outs; o++) begin
              acc = 0;
              for (int j = 0; j < esn_pkg::Res; j++)
                acc += longint'(out_w[o*esn_pkg::Res + j]) * state[j];
              w = '{esn_pkg::KindReadout, 6'(o), sat_q12(acc), o == esn_pkg::Outs - 1};
              pending_words = {pending_words, w};
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_result(input esn_word_t got);
      esn_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word kind=%0d index=%0d value=%0d",
                         got.kind, got.index, got.value));
      end else begin
        want = pending_words.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.index !== want.index)
          report($sformatf("index %0d, want %0d", got.index, want.index));
        if (got.value !== want.value)
          report($sformatf("value %0d, want %0d (kind %0d index %0d)",
                           got.value, want.value, want.kind, want.index));
        if (got.fin !== want.fin)
          report($sformatf("final %0d, want %0d", got.fin, want.fin));
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         command_i;
  logic [5:0]         row_i;
  logic [5:0]         column_i;
  logic signed [15:0] value_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               kind_o;
  logic [5:0]         index_o;
  logic signed [15:0] result_value_o;
  logic               final_res_o;
  logic               cfg_we_i;
  logic [12:0]        cfg_wdata_i;

  esn_scoreboard sb = new();
  bit            quiet = 1'b0;

  echo_state_network_step_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .command_i(command_i), .row_i(row_i), .column_i(column_i),
    .value_i(value_i), .last_i(last_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .kind_o(kind_o), .index_o(index_o), .result_value_o(result_value_o),
    .final_res_o(final_res_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #80_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check accepted words, stall in random bursts.
  initial begin
    int        stall_left;
    esn_word_t got;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.kind = kind_o;
        got.index = index_o;
        got.value = result_value_o;
        got.fin = final_res_o;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task send_word(input logic [2:0] cmd, input logic [5:0] row, input logic [5:0] col,
                 input logic signed [15:0] val, input logic last);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    row_i <= row;
    column_i <= col;
    value_i <= val;
    last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, row, col, val, last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Hold until every word is out, then let trailing load words settle.
  task wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_leak(input logic [12:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.leak = v;
  endtask

  function logic signed [15:0] pick_value();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1023)) - 16'sd512;
  endfunction

  task send_random();
    int          r;
    logic [2:0]  cmd;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        last;
    r = $urandom_range(0, 99);
    last = 1'b0;
    row = 6'($urandom_range(0, esn_pkg::Res - 1));
    col = 6'($urandom_range(0, esn_pkg::Res - 1));
    if (r < 30) begin
      cmd = esn_pkg::CmdRecW;
    end else if (r < 40) begin
      cmd = esn_pkg::CmdInW;
      col = 6'($urandom_range(0, esn_pkg::Inp - 1));
    end else if (r < 50) begin
      cmd = esn_pkg::CmdOutW;
      row = 6'($urandom_range(0, esn_pkg::Outs - 1));
    end else if (r < 85) begin
      cmd = esn_pkg::CmdSample;
      col = ($urandom_range(0, 19) == 0) ? 6'($urandom) :
            6'($urandom_range(0, esn_pkg::Inp - 1));
      row = 6'($urandom);
      last = ($urandom_range(0, 7) == 0);
    end else if (r < 90) begin
      cmd = esn_pkg::CmdClear;
      last = 1'($urandom);
    end else if (r < 94) begin
      cmd = 3'($urandom_range(esn_pkg::CmdClear + 1, CmdTop));
      last = 1'($urandom);
    end else begin
      // noise: any row and column, ignored when out of range
      cmd = 3'($urandom_range(esn_pkg::CmdRecW, esn_pkg::CmdClear));
      row = 6'($urandom);
      col = 6'($urandom);
      last = 1'($urandom);
    end
    send_word(cmd, row, col, pick_value(), last);
  endtask

  initial begin
    logic [12:0] leaks[5];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = esn_pkg::CmdRecW;
    row_i = '0;
    column_i = '0;
    value_i = '0;
    last_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every weight before any step reads them.
    for (int i = 0; i < esn_pkg::Res; i++)
      for (int j = 0; j < esn_pkg::Res; j++)
        send_word(esn_pkg::CmdRecW, 6'(i), 6'(j), pick_value(), 1'b0);
    for (int i = 0; i < esn_pkg::Res; i++)
      for (int j = 0; j < esn_pkg::Inp; j++)
        send_word(esn_pkg::CmdInW, 6'(i), 6'(j), pick_value(), 1'b0);
    for (int i = 0; i < esn_pkg::Outs; i++)
      for (int j = 0; j < esn_pkg::Res; j++)
        send_word(esn_pkg::CmdOutW, 6'(i), 6'(j), pick_value(), 1'b0);

    // Directed: sample extremes, ignored loads, stray last bits, clear, saturation.
    send_word(esn_pkg::CmdSample, 6'd63, 6'd0, 16'sh7fff, 1'b0);
    send_word(esn_pkg::CmdSample, 6'd0, 6'd1, -16'sh8000, 1'b0);
    send_word(esn_pkg::CmdSample, 6'd0, 6'd2, 16'sd0, 1'b0);
    send_word(esn_pkg::CmdSample, 6'd0, 6'(esn_pkg::Inp - 1), 16'sd1, 1'b1);
    send_word(esn_pkg::CmdSample, 6'd0, 6'd63, 16'sd5, 1'b1);
    send_word(esn_pkg::CmdRecW, 6'd63, 6'd0, 16'sh7fff, 1'b0);
    send_word(esn_pkg::CmdInW, 6'd0, 6'(esn_pkg::Inp), 16'sh7fff, 1'b0);
    send_word(esn_pkg::CmdOutW, 6'(esn_pkg::Outs), 6'd0, 16'sh7fff, 1'b0);
    send_word(esn_pkg::CmdOutW, 6'd0, 6'd63, 16'sh7fff, 1'b0);
    send_word(CmdSpareLo, 6'd0, 6'd0, 16'sd0, 1'b1);
    send_word(CmdSpareMid, 6'd63, 6'd63, 16'shffff, 1'b1);
    send_word(CmdTop, 6'd0, 6'd0, 16'sd0, 1'b1);
    send_word(esn_pkg::CmdRecW, 6'd0, 6'd0, 16'sh7fff, 1'b1);
    send_word(esn_pkg::CmdInW, 6'd0, 6'd0, 16'sh7fff, 1'b0);
    send_word(esn_pkg::CmdInW, 6'd1, 6'd0, -16'sh8000, 1'b0);
    send_word(esn_pkg::CmdSample, 6'd0, 6'd0, 16'sh7fff, 1'b1);
    send_word(esn_pkg::CmdClear, 6'd0, 6'd0, 16'sd0, 1'b1);
    send_word(esn_pkg::CmdSample, 6'd0, 6'd0, -16'sh8000, 1'b1);

    leaks = '{13'd0, 13'h1fff, 13'd4096, 13'($urandom_range(1, 4095)), 13'd1};
    for (int p = 0; p < 5; p++) begin
      write_leak(leaks[p]);
      if (p == 4) quiet = 1'b1;
      for (int n = 0; n < 92; n++) begin
        if (n == 46 && p == 1) wait_drained();
        send_random();
      end
      send_word(esn_pkg::CmdSample, 6'd0, 6'($urandom_range(0, esn_pkg::Inp - 1)),
                pick_value(), 1'b1);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/esn_pkg.sv
rtl/core/esn_dp.sv
rtl/core/esn_ctrl.sv
rtl/core/echo_state_network_step_unit.sv
verif/echo_state_network_step_unit_test.sv
